### hw/rtl/cte_pkg.sv
package cte_pkg;

   localparam int unsigned YEAR_W    = 16;
   localparam int unsigned DAYS_W    = 25;
   localparam int unsigned HMS_W     = 22;
   localparam int unsigned DSEC_W    = 42;
   localparam int unsigned EPOCH_W   = 41;
   localparam int unsigned QUOT_W    = 10;
   localparam int unsigned OFFSET_W  = 9;
   localparam int unsigned ZONE_W    = 12;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 16'd1970;
   localparam logic [8:0]        DAYS_PER_YEAR      = 9'd365;
   localparam logic [8:0]        LEAPS_BEFORE_EPOCH = 9'd477;
   localparam logic [16:0]       SEC_PER_DAY        = 17'd86400;
   localparam logic [11:0]       SEC_PER_HOUR       = 12'd3600;
   localparam logic [5:0]        SEC_PER_MIN        = 6'd60;
   localparam logic [6:0]        YEARS_PER_CENTURY  = 7'd100;
   localparam logic [6:0]        LAST_IN_CENTURY    = 7'd99;
   localparam int                ZONE_LIMIT         = 1440;
   localparam logic [31:0]       RECIP_100          = 32'h51EB851F;
   localparam int unsigned       RECIP_SHIFT        = 37;

   localparam logic [7:0] MONTH_FIRST = 8'd1;
   localparam logic [7:0] MONTH_LAST  = 8'd12;
   localparam logic [7:0] MONTH_FEB   = 8'd2;
   localparam logic [7:0] DAY_FIRST   = 8'd1;
   localparam logic [7:0] DAY_LAST    = 8'd31;

   function automatic logic [OFFSET_W-1:0] month_offset(input logic [3:0] month);
      logic [OFFSET_W-1:0] days;
      unique case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

### hw/rtl/calendar_to_epoch_seconds.sv
// Calendar timestamp to seconds since 1970-01-01 00:00 UTC.
// Input channel req_*: one transaction carries year, month, day, hour,
// minute, second and a UTC offset in minutes. Output channel rsp_*: one
// transaction per input carries the 41-bit epoch second count.
// Invalid dates (year before 1970, month outside 1..12, day outside 1..31)
// and negative totals give zero; offsets beyond +-1440 minutes are ignored.
// An accepted input passes through stage registers s1 to s4 and the output register before rsp_valid.
// Throughput: one transaction per cycle while rsp_ready holds, set by the
// five-stage pipeline (reciprocal divide by 100, day count, day sum,
// day-to-second multiply, final add and clamp).
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up. When the receiver stalls, the
// result holds in the output register and the stages behind it keep
// filling; req_ready drops only once all five stages are full.
// Reset (synchronous, active high) empties the pipeline; payload is kept.
module calendar_to_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cal_year,
   input  logic [7:0]  req_cal_month,
   input  logic [7:0]  req_cal_day,
   input  logic [7:0]  req_cal_hour,
   input  logic [7:0]  req_cal_minute,
   input  logic [7:0]  req_cal_second,
   input  logic signed [15:0] req_zone_minutes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [40:0] rsp_epoch_seconds
);
   import cte_pkg::*;

   logic s1_en, s2_en, s3_en, s4_en, out_en;

   logic                     s1_valid_ff, s1_bad_ff, s1_late_ff;
   logic [YEAR_W-1:0]        s1_span_ff, s1_ym1_ff;
   logic [QUOT_W-1:0]        s1_quot_ff;
   logic [OFFSET_W-1:0]      s1_offset_ff;
   logic [4:0]               s1_daym1_ff;
   logic [7:0]               s1_hour_ff, s1_minute_ff, s1_second_ff;
   logic signed [ZONE_W-1:0] s1_zone_ff;
   logic                     s1_bad_in, s1_zone_ok;
   logic [47:0]              s1_prod;
   logic [YEAR_W-1:0]        s1_ym1_in;

   logic                     s2_valid_ff, s2_bad_ff, s2_late_ff, s2_leap_ff;
   logic [DAYS_W-1:0]        s2_dyear_ff, s2_dyear_in;
   logic [OFFSET_W-1:0]      s2_offset_ff;
   logic [4:0]               s2_daym1_ff;
   logic signed [HMS_W-1:0]  s2_hms_ff, s2_hms_in, s2_zoff;
   logic [19:0]              s2_clock_sec;
   logic [16:0]              s2_cent;
   logic [YEAR_W-1:0]        s2_rem;
   logic                     s2_c100, s2_leap_in;

   logic                     s3_valid_ff, s3_bad_ff;
   logic [DAYS_W-1:0]        s3_days_ff, s3_days_in;
   logic signed [HMS_W-1:0]  s3_hms_ff;

   logic                     s4_valid_ff, s4_bad_ff;
   logic [DSEC_W-1:0]        s4_dsec_ff, s4_dsec_in;
   logic signed [HMS_W-1:0]  s4_hms_ff;

   logic                     rsp_valid_ff;
   logic [EPOCH_W-1:0]       rsp_epoch_ff, rsp_epoch_in;
   logic signed [DSEC_W:0]   total;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s4_en     = !s4_valid_ff || out_en;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   // stage 1: validate, reciprocal divide of (year - 1) by 100, month table
   always_comb begin
      s1_bad_in  = (req_cal_year < EPOCH_YEAR) ||
                   (req_cal_month < MONTH_FIRST) || (req_cal_month > MONTH_LAST) ||
                   (req_cal_day < DAY_FIRST) || (req_cal_day > DAY_LAST);
      s1_zone_ok = (req_zone_minutes >= -16'sd1440) && (req_zone_minutes <= 16'sd1440);
      s1_ym1_in  = req_cal_year - 16'd1;
      s1_prod    = 48'(s1_ym1_in) * 48'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_en) begin
         s1_bad_ff    <= s1_bad_in;
         s1_span_ff   <= req_cal_year - EPOCH_YEAR;
         s1_ym1_ff    <= s1_ym1_in;
         s1_quot_ff   <= s1_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
         s1_offset_ff <= month_offset(req_cal_month[3:0]);
         s1_late_ff   <= req_cal_month > MONTH_FEB;
         s1_daym1_ff  <= 5'(req_cal_day - DAY_FIRST);
         s1_hour_ff   <= req_cal_hour;
         s1_minute_ff <= req_cal_minute;
         s1_second_ff <= req_cal_second;
         s1_zone_ff   <= s1_zone_ok ? ZONE_W'(req_zone_minutes) : '0;
      end
   end

   // stage 2: days before the year, leap flag, time of day less zone
   always_comb begin
      s2_dyear_in = DAYS_W'(s1_span_ff) * DAYS_W'(DAYS_PER_YEAR)
                  + DAYS_W'(s1_ym1_ff[YEAR_W-1:2])
                  + DAYS_W'(s1_quot_ff[QUOT_W-1:2])
                  - DAYS_W'(s1_quot_ff)
                  - DAYS_W'(LEAPS_BEFORE_EPOCH);
      s2_cent     = 17'(s1_quot_ff) * 17'(YEARS_PER_CENTURY);
      s2_rem      = s1_ym1_ff - s2_cent[YEAR_W-1:0];
      s2_c100     = s2_rem == YEAR_W'(LAST_IN_CENTURY);
      s2_leap_in  = ((s1_ym1_ff[1:0] == 2'b11) && !s2_c100) ||
                    (s2_c100 && (s1_quot_ff[1:0] == 2'b11));
      s2_clock_sec = 20'(s1_hour_ff) * 20'(SEC_PER_HOUR)
                   + 20'(s1_minute_ff) * 20'(SEC_PER_MIN)
                   + 20'(s1_second_ff);
      s2_zoff     = HMS_W'(s1_zone_ff) * $signed(HMS_W'(SEC_PER_MIN));
      s2_hms_in   = $signed({2'b00, s2_clock_sec}) - s2_zoff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_bad_ff    <= s1_bad_ff;
         s2_dyear_ff  <= s2_dyear_in;
         s2_leap_ff   <= s2_leap_in;
         s2_late_ff   <= s1_late_ff;
         s2_offset_ff <= s1_offset_ff;
         s2_daym1_ff  <= s1_daym1_ff;
         s2_hms_ff    <= s2_hms_in;
      end
   end

   // stage 3: total day count
   assign s3_days_in = s2_dyear_ff + DAYS_W'(s2_offset_ff)
                     + DAYS_W'(s2_leap_ff && s2_late_ff) + DAYS_W'(s2_daym1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_en) begin
         s3_bad_ff  <= s2_bad_ff;
         s3_days_ff <= s3_days_in;
         s3_hms_ff  <= s2_hms_ff;
      end
   end

   // stage 4: days to seconds
   assign s4_dsec_in = DSEC_W'(s3_days_ff) * DSEC_W'(SEC_PER_DAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_en) begin
         s4_bad_ff  <= s3_bad_ff;
         s4_dsec_ff <= s4_dsec_in;
         s4_hms_ff  <= s3_hms_ff;
      end
   end

   // stage 5: add time of day, clamp negative and invalid to zero
   always_comb begin
      total        = $signed({1'b0, s4_dsec_ff}) + (DSEC_W+1)'(s4_hms_ff);
      rsp_epoch_in = (s4_bad_ff || total <= 0) ? '0 : total[EPOCH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (out_en) begin
         rsp_epoch_ff <= rsp_epoch_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_zone_ff >= -12'sd1440) && (s1_zone_ff <= 12'sd1440))
      else $error("zone offset beyond limit passed");

   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_bad_ff && out_en) |=> (rsp_epoch_seconds == '0))
      else $error("invalid date gave nonzero seconds");

endmodule
